// ===== hdl/erld_pkg.sv =====
`default_nettype none

package erld_pkg;

   // escape byte that opens a run group, and the length of that group
   localparam logic [7:0] EscByte  = 8'hED;
   localparam logic [2:0] GroupLen = 3'd4;

   // destination size after reset
   localparam logic [15:0] DestReset = 16'd16384;

   // result queue: one request can raise up to five results
   localparam int ResultDepth = 8;
   localparam int ResultIdxW  = $clog2(ResultDepth);
   localparam int ResultCntW  = $clog2(ResultDepth + 1);
   // the queue takes a request only while at least this many slots are free
   localparam int MaxResults  = 5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  fill_value;
      logic [15:0] repeat_res;
      logic        status;
      logic [15:0] consumed;
      logic        block_end;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/escape_run_length_decoder.sv =====
// results: a taken request writes its results into the result queue, and rsp offers them from its head
// throughput: one request per cycle while each request raises at most one
//    result and rsp_stall is low; a final byte raises up to five results,
//    drained from an eight-entry result queue one per cycle while rsp_stall
//    is low, and req_stall rises while fewer than five queue slots are free
// reset: synchronous, clears the window, counters and queue; dest_size = 16384
`default_nettype none

module escape_run_length_decoder
   import erld_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // compressed byte requests
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // decoded results
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // destination size register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   // block state
   logic [15:0] dest_ff, dest_in;
   logic [7:0]  pend_ff [3];
   logic [7:0]  pend_in [3];
   logic [1:0]  pcnt_ff, pcnt_in;
   logic [15:0] room_ff, room_in;
   logic [15:0] cons_ff, cons_in;
   logic        full_ff, full_in;
   logic        err_ff, err_in;
   logic        open_ff, open_in;

   // result queue
   rsp_type                 queue_ff [ResultDepth];
   logic [ResultIdxW-1:0]   head_ff, head_in;
   logic [ResultIdxW-1:0]   tail_ff, tail_in;
   logic [ResultCntW-1:0]   count_ff, count_in;

   // decode of the current request
   logic        req_take;
   logic        rsp_take;
   logic [15:0] room0;
   logic        full0;
   logic        take_new;
   logic [2:0]  nn;
   logic [7:0]  win [4];
   logic        is_run;
   logic        is_lit;
   logic [15:0] run_cnt;
   logic        run_err;
   logic [15:0] run_len;
   logic [2:0]  lit_n;
   logic [2:0]  body_n;
   logic [2:0]  res_n;
   logic [2:0]  used;
   logic [15:0] room1;
   logic [16:0] cons_sum;
   logic [15:0] cons1;
   logic        err1;
   rsp_type     run_res;
   rsp_type     close_res;
   rsp_type     res [ResultDepth];

   // handshakes
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;
   assign req_stall = count_ff > ResultCntW'(ResultDepth - MaxResults);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[head_ff];

   // window assembly and group decision
   always_comb begin
      room0    = open_ff ? room_ff : dest_ff;
      full0    = open_ff ? full_ff : (dest_ff == 16'd0);
      take_new = !full0;
      nn       = {1'b0, pcnt_ff} + {2'b00, take_new};
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < pcnt_ff) begin
            win[i] = pend_ff[i];
         end else if (2'(i) == pcnt_ff && take_new) begin
            win[i] = req_data.data_byte;
         end else begin
            win[i] = 8'h00;
         end
      end
      win[3] = (pcnt_ff == 2'd3 && take_new) ? req_data.data_byte : 8'h00;

      is_run = !full0 && nn == GroupLen && win[0] == EscByte && win[1] == EscByte;
      is_lit = !full0 && !is_run && (nn == GroupLen || req_data.final_byte);

      // run length clipped to the room left
      run_cnt = {8'h00, win[2]};
      run_err = run_cnt > room0;
      run_len = run_err ? room0 : run_cnt;

      // literals: one per byte, or on the final byte the whole window clipped to the room left
      if (!req_data.final_byte) begin
         lit_n = 3'd1;
      end else if (room0 >= {13'd0, nn}) begin
         lit_n = nn;
      end else begin
         lit_n = room0[2:0];
      end

      if (is_run) begin
         body_n = 3'd1;
         used   = GroupLen;
         room1  = room0 - run_len;
      end else if (is_lit) begin
         body_n = lit_n;
         used   = lit_n;
         room1  = room0 - {13'd0, lit_n};
      end else begin
         body_n = 3'd0;
         used   = 3'd0;
         room1  = room0;
      end
      res_n = body_n + {2'b00, req_data.final_byte};

      // saturating consumed count
      cons_sum = {1'b0, cons_ff} + {14'd0, used};
      cons1    = cons_sum[16] ? 16'hFFFF : cons_sum[15:0];
      err1     = err_ff || (is_run && run_err);

      run_res.fill_value = win[3];
      run_res.repeat_res = run_len;
      run_res.status     = run_err;
      run_res.consumed   = 16'd0;
      run_res.block_end  = 1'b0;

      close_res.fill_value = 8'h00;
      close_res.repeat_res = room1;
      close_res.status     = err1;
      close_res.consumed   = cons1;
      close_res.block_end  = 1'b1;

      // ordered result list: body results first, closing result after
      for (int i = 0; i < ResultDepth; i++) begin
         if (3'(i) < body_n && i < 4) begin
            if (is_run) begin
               res[i] = run_res;
            end else begin
               res[i].fill_value = win[2'(i)];
               res[i].repeat_res = 16'd1;
               res[i].status     = 1'b0;
               res[i].consumed   = 16'd0;
               res[i].block_end  = 1'b0;
            end
         end else begin
            res[i] = close_res;
         end
      end
   end

   // next block state
   always_comb begin
      dest_in = dest_ff;
      pend_in = pend_ff;
      pcnt_in = pcnt_ff;
      room_in = room_ff;
      cons_in = cons_ff;
      full_in = full_ff;
      err_in  = err_ff;
      open_in = open_ff;
      if (csr_valid && csr_ready) begin
         dest_in = csr_data;
      end
      if (req_take) begin
         if (req_data.final_byte) begin
            pend_in = '{8'h00, 8'h00, 8'h00};
            pcnt_in = 2'd0;
            room_in = dest_ff;
            cons_in = 16'd0;
            full_in = 1'b0;
            err_in  = 1'b0;
            open_in = 1'b0;
         end else begin
            if (is_run) begin
               pend_in = '{8'h00, 8'h00, 8'h00};
               pcnt_in = 2'd0;
            end else if (is_lit) begin
               pend_in = '{win[1], win[2], win[3]};
               pcnt_in = 2'd3;
            end else begin
               pend_in = '{win[0], win[1], win[2]};
               pcnt_in = nn[1:0];
            end
            room_in = room1;
            cons_in = cons1;
            full_in = full0 || (room1 == 16'd0);
            err_in  = err1;
            open_in = 1'b1;
         end
      end
   end

   // next queue pointers
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (rsp_take) begin
         head_in  = head_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
      if (req_take) begin
         tail_in  = tail_ff + res_n;
         count_in = count_in + ResultCntW'(res_n);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff  <= DestReset;
         pend_ff  <= '{8'h00, 8'h00, 8'h00};
         pcnt_ff  <= 2'd0;
         room_ff  <= DestReset;
         cons_ff  <= 16'd0;
         full_ff  <= 1'b0;
         err_ff   <= 1'b0;
         open_ff  <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         dest_ff  <= dest_in;
         pend_ff  <= pend_in;
         pcnt_ff  <= pcnt_in;
         room_ff  <= room_in;
         cons_ff  <= cons_in;
         full_ff  <= full_in;
         err_ff   <= err_in;
         open_ff  <= open_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // result queue storage: each request writes its results from the tail on
   always_ff @(posedge clock) begin
      for (int j = 0; j < ResultDepth; j++) begin
         if (req_take && ResultIdxW'(ResultIdxW'(j) - tail_ff) < res_n) begin
            queue_ff[j] <= res[ResultIdxW'(ResultIdxW'(j) - tail_ff)];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/erld_checker.sv =====
`default_nettype none

module erld_checker
   import erld_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a result waiting on a stall stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // reset empties the result queue and opens the request side
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

   // the closing result fills with zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.block_end |-> rsp_data.fill_value == 8'h00)
      else $error("closing result with nonzero fill");

   // only the closing result carries the consumed count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.block_end |-> rsp_data.consumed == 16'd0)
      else $error("consumed count on a body result");

   // a clipped run still writes the remaining room, which is never empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status && !rsp_data.block_end
         |-> rsp_data.repeat_res != 16'd0)
      else $error("clipped run with zero length");

endmodule

bind escape_run_length_decoder erld_checker u_erld_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== dv/escape_run_length_decoder_tb.sv =====
`default_nettype none

module escape_run_length_decoder_tb;
   import erld_pkg::*;

   localparam logic StatusOk      = 1'b0;
   localparam logic StatusOverrun = 1'b1;
   localparam int   RunLimit      = 2_000_000;

   typedef logic [7:0] byte_queue_type [$];

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   // decoder state as the testbench tracks it
   logic [15:0] size_reg;
   logic [7:0]  window_buf [3];
   int          window_cnt;
   logic [15:0] space_left;
   logic [15:0] bytes_taken;
   bit          dest_full;
   bit          overrun_seen;
   bit          block_active;

   rsp_type     expected_fills [$];
   int          fail_count = 0;
   bit          idle_on;
   int          rsp_hold_cycles;
   int          rsp_hold_req;

   escape_run_length_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #RunLimit;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // expected decoding
   // ---------------------------------------------------------------

   function automatic void close_block();
      window_buf   = '{default: 8'h00};
      window_cnt   = 0;
      space_left   = size_reg;
      bytes_taken  = 16'd0;
      dest_full    = 1'b0;
      overrun_seen = 1'b0;
      block_active = 1'b0;
   endfunction

   function automatic void set_dest_size(input logic [15:0] bytes);
      size_reg = bytes;
      if (!block_active)
         space_left = bytes;
   endfunction

   function automatic void decode_byte(input req_type item);
      logic [7:0]  win [4];
      int          n;
      int          take;
      int          sum;
      logic [15:0] cnt;
      rsp_type     res;
      if (!block_active) begin
         block_active = 1'b1;
         space_left   = size_reg;
         dest_full    = (space_left == 16'd0);
      end
      n = window_cnt;
      for (int i = 0; i < n; i++)
         win[i] = window_buf[i];
      if (!dest_full) begin
         win[n] = item.data_byte;
         n++;
      end
      // decide bytes while a full group is buffered or the block ends
      while (n > 0 && !dest_full) begin
         res = '0;
         if (n == GroupLen && win[0] == EscByte && win[1] == EscByte) begin
            cnt            = {8'h00, win[2]};
            res.fill_value = win[3];
            res.status     = StatusOk;
            if (cnt > space_left) begin
               cnt          = space_left;
               res.status   = StatusOverrun;
               overrun_seen = 1'b1;
            end
            res.repeat_res = cnt;
            space_left     = space_left - cnt;
            take           = GroupLen;
         end else if (n == GroupLen || item.final_byte) begin
            res.fill_value = win[0];
            res.repeat_res = 16'd1;
            space_left     = space_left - 16'd1;
            take           = 1;
         end else begin
            break;
         end
         expected_fills.push_back(res);
         sum         = bytes_taken + take;
         bytes_taken = (sum > 65535) ? 16'hFFFF : sum[15:0];
         for (int i = 0; i + take < n; i++)
            win[i] = win[i + take];
         n = n - take;
         if (space_left == 16'd0)
            dest_full = 1'b1;
      end
      if (item.final_byte) begin
         res            = '0;
         res.repeat_res = space_left;
         res.status     = overrun_seen ? StatusOverrun : StatusOk;
         res.consumed   = bytes_taken;
         res.block_end  = 1'b1;
         expected_fills.push_back(res);
         close_block();
      end else begin
         if (n > 3)
            n = 3;
         window_buf = '{default: 8'h00};
         for (int i = 0; i < n; i++)
            window_buf[i] = win[i];
         window_cnt = n;
      end
   endfunction

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         fail_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   function automatic void check_result(input rsp_type got);
      rsp_type want;
      if (expected_fills.size() == 0) begin
         fail_count++;
         $error("result with no request behind it: fill_value %0d repeat_res %0d",
                got.fill_value, got.repeat_res);
         return;
      end
      want = expected_fills.pop_front();
      compare_field("fill_value", want.fill_value, got.fill_value);
      compare_field("repeat_res", want.repeat_res, got.repeat_res);
      compare_field("status", want.status, got.status);
      compare_field("consumed", want.consumed, got.consumed);
      compare_field("block_end", want.block_end, got.block_end);
   endfunction

   // track register writes, requests and results at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         size_reg = DestReset;
         close_block();
         expected_fills.delete();
      end else begin
         if (csr_valid && csr_ready)
            set_dest_size(csr_data);
         if (req_valid && !req_stall)
            decode_byte(req_data);
         if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
      end
   end

   // result side: random stall bursts, or one long hold when asked
   initial begin : rsp_side
      int n;
      int hold_served;
      rsp_stall   = 1'b0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req != hold_served) begin
            hold_served = rsp_hold_req;
            n           = rsp_hold_cycles;
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------

   task automatic send_byte(input logic [7:0] data, input logic last);
      int      gap;
      req_type item;
      gap  = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
      item = '{data_byte: data, final_byte: last};
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_block(input byte_queue_type bytes);
      foreach (bytes[i])
         send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // stop offering requests and let every expected result come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_fills.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_dest_size(input logic [15:0] bytes);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= bytes;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // literals, runs, zero-length run and groups near the block end
   task automatic test_window_and_runs();
      byte_queue_type blk;
      blk = '{8'h00, 8'hFF, EscByte, EscByte, 8'h05, 8'hAA,
              EscByte, EscByte, 8'h00, 8'h55, 8'h12, 8'h34};
      send_block(blk);
      // group completed by the last byte still counts as a run
      blk = '{EscByte, EscByte, 8'h07, 8'h42};
      send_block(blk);
      // escape pair with fewer than four bytes left stays literal
      blk = '{EscByte, EscByte, 8'h07};
      send_block(blk);
      blk = '{8'h80};
      send_block(blk);
      // three pending bytes plus the last one: most results from one request
      blk = '{EscByte, 8'h10, 8'h20, 8'h30};
      send_block(blk);
   endtask

   // destination sizes at the edges, overrun, dropped bytes, late writes
   task automatic test_dest_size_limits();
      byte_queue_type blk;
      // run longer than the room left, then the rest is dropped
      write_dest_size(16'd6);
      blk = '{EscByte, EscByte, 8'h0A, 8'h77, 8'h11, 8'h22, 8'h33};
      send_block(blk);
      write_dest_size(16'd1);
      blk = '{8'h05, 8'h06};
      send_block(blk);
      // fills up while bytes are still pending
      write_dest_size(16'd2);
      blk = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
      send_block(blk);
      write_dest_size(16'hFFFF);
      blk = '{EscByte, EscByte, 8'hFF, 8'h01, 8'h02};
      send_block(blk);
      // a write inside an open block only counts from the next block
      write_dest_size(16'd10);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      write_dest_size(16'd3);
      send_byte(8'h03, 1'b0);
      send_byte(8'h04, 1'b1);
      blk = '{8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5};
      send_block(blk);
   endtask

   // long result hold fills the queue, then the sender waits for a drain
   task automatic test_result_backpressure();
      byte_queue_type blk;
      write_dest_size(16'd300);
      rsp_hold_cycles = 150;
      rsp_hold_req++;
      for (int i = 0; i < 30; i++)
         send_byte(8'($urandom_range(0, 8'hEC)), 1'b0);
      send_byte(8'h01, 1'b1);
      wait_drained();
      blk = '{EscByte, EscByte, 8'h03, 8'hC3, 8'h9E};
      send_block(blk);
   endtask

   // zero-length runs take input without using room
   task automatic test_zero_length_runs();
      write_dest_size(16'hFFFF);
      repeat (4) begin
         send_byte(EscByte, 1'b0);
         send_byte(EscByte, 1'b0);
         send_byte(8'h00, 1'b0);
         send_byte(8'($urandom), 1'b0);
      end
      send_byte(8'h5A, 1'b1);
   endtask

   // random blocks: mostly run groups, some literals and broken escapes
   task automatic test_random_blocks(input int item_goal);
      byte_queue_type blk;
      int             sent;
      int             kind;
      logic [7:0]     cnt;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0: begin
                  write_dest_size(16'd1);
               end
               1: begin
                  write_dest_size(16'hFFFF);
               end
               2, 3: begin
                  write_dest_size(16'($urandom_range(2, 48)));
               end
               default: begin
                  write_dest_size(16'($urandom_range(49, 4000)));
               end
            endcase
         end
         blk.delete();
         repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
               cnt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
               blk.push_back(EscByte);
               blk.push_back(EscByte);
               blk.push_back(cnt);
               blk.push_back(8'($urandom));
            end else if (kind < 17) begin
               blk.push_back(8'($urandom));
            end else if (kind < 19) begin
               // lone escape byte
               blk.push_back(EscByte);
               blk.push_back(8'($urandom_range(0, 8'hEC)));
            end else begin
               // escape pair cut short
               blk.push_back(EscByte);
               blk.push_back(EscByte);
            end
         end
         send_block(blk);
         sent += blk.size();
      end
   endtask

   initial begin : stimulus
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      idle_on         = 1'b1;
      rsp_hold_cycles = 0;
      rsp_hold_req    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_window_and_runs();
      test_dest_size_limits();
      test_result_backpressure();
      test_zero_length_runs();
      test_random_blocks(80);
      // closing stretch runs at full rate on both sides
      wait_drained();
      idle_on = 1'b0;
      test_random_blocks(25);
      wait_drained();
      repeat (8) @(posedge clock);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
